FILE: src/assert_macros.svh
// Assertion macros for the top-level RTL file of the debug packet deframer.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that is suspended while reset is asserted.
`define DPD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
// Check that also runs through reset.
`define DPD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DPD_ASSERT(label, clk, rst_n, prop, msg)
`define DPD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: src/dpd_pkg.sv
// Package for the debug packet deframer: framing characters, event codes,
// phase type and the hex digit decoder. No dependencies.
package dpd_pkg;

    // Default payload limit and width of the reported length
    localparam int DEFAULT_MAX_PAYLOAD = 512;
    localparam int LEN_W               = 10;
    localparam int EVENT_W             = 4;

    // Framing and control characters
    localparam logic [7:0] CH_START = 8'h24;  // '$'
    localparam logic [7:0] CH_END   = 8'h23;  // '#'
    localparam logic [7:0] CH_ACK   = 8'h2B;  // '+'
    localparam logic [7:0] CH_NACK  = 8'h2D;  // '-'
    localparam logic [7:0] CH_BREAK = 8'h03;  // ctrl-C

    // Hex digit ranges
    localparam logic [7:0] CH_DIG_LO = 8'h30;
    localparam logic [7:0] CH_DIG_HI = 8'h39;
    localparam logic [7:0] CH_LC_LO  = 8'h61;
    localparam logic [7:0] CH_LC_HI  = 8'h66;
    localparam logic [7:0] CH_UC_LO  = 8'h41;
    localparam logic [7:0] CH_UC_HI  = 8'h46;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE      = 4'd0,
        EV_DATA      = 4'd1,
        EV_GOOD      = 4'd2,
        EV_BADSUM    = 4'd3,
        EV_BREAK     = 4'd4,
        EV_ACK       = 4'd5,
        EV_NACK      = 4'd6,
        EV_BADDIGIT  = 4'd7,
        EV_DROP      = 4'd8
    } t_event;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DIGIT1  = 2'd2,
        PH_DIGIT2  = 2'd3
    } t_phase;

    // Phase and checksum travel together between top level and decoder
    typedef struct packed {
        t_phase     phase;
        logic [7:0] sum;
    } t_core;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } t_hex;

    // Decode one ASCII hex digit, either case
    function automatic t_hex hex_decode(input logic [7:0] b);
        t_hex h;
        h.ok  = 1'b1;
        h.nib = 4'h0;
        priority if (b >= CH_DIG_LO && b <= CH_DIG_HI) begin
            h.nib = b[3:0];
        end else if (b >= CH_LC_LO && b <= CH_LC_HI) begin
            h.nib = 4'(b - CH_LC_LO + 8'd10);
        end else if (b >= CH_UC_LO && b <= CH_UC_HI) begin
            h.nib = 4'(b - CH_UC_LO + 8'd10);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

FILE: src/dpd_in_if.sv
// Input channel of the debug packet deframer: one received byte per item.
// No dependencies.
interface dpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: src/dpd_out_if.sv
// Output channel of the debug packet deframer: one event per item.
// Depends on dpd_pkg for field widths.
interface dpd_out_if;
    logic                          valid;
    logic                          ready;
    logic [dpd_pkg::EVENT_W-1:0]   event_res;
    logic [7:0]                    data_byte;
    logic [dpd_pkg::LEN_W-1:0]     payload_length;

    modport source (output valid, output event_res, output data_byte,
                    output payload_length, input ready);
    modport sink   (input valid, input event_res, input data_byte,
                    input payload_length, output ready);
endinterface

FILE: src/dpd_decoder.sv
// Per-byte step of the deframer: next phase, checksum, count and event.
// Depends on dpd_pkg.
module dpd_decoder #(
    parameter int MAX_PAYLOAD = dpd_pkg::DEFAULT_MAX_PAYLOAD,
    parameter int CNT_W       = $clog2(MAX_PAYLOAD + 1)
) (
    input  logic [7:0]       i_byte,
    input  dpd_pkg::t_core   i_core,
    input  logic [CNT_W-1:0] i_count,
    output dpd_pkg::t_core   o_core,
    output logic [CNT_W-1:0] o_count,
    output dpd_pkg::t_event  o_event,
    output logic [7:0]       o_data
);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);

    dpd_pkg::t_hex   hex;
    logic            full;
    logic [7:0]      sum_lo;
    dpd_pkg::t_phase ph_next;
    logic [7:0]      sum_next;

    assign hex    = dpd_pkg::hex_decode(i_byte);
    assign full   = (i_count >= CNT_MAX);
    assign sum_lo = i_core.sum ^ {4'h0, hex.nib};

    assign o_core = '{phase: ph_next, sum: sum_next};

    // Next phase
    always_comb begin
        ph_next = i_core.phase;
        unique case (i_core.phase)
            dpd_pkg::PH_IDLE: begin
                if (i_byte == dpd_pkg::CH_START) ph_next = dpd_pkg::PH_PAYLOAD;
            end
            dpd_pkg::PH_PAYLOAD: begin
                if (i_byte == dpd_pkg::CH_END) ph_next = dpd_pkg::PH_DIGIT1;
            end
            dpd_pkg::PH_DIGIT1: begin
                ph_next = hex.ok ? dpd_pkg::PH_DIGIT2 : dpd_pkg::PH_IDLE;
            end
            dpd_pkg::PH_DIGIT2: begin
                ph_next = dpd_pkg::PH_IDLE;
            end
        endcase
    end

    // Checksum, count and event
    always_comb begin
        sum_next = i_core.sum;
        o_count  = i_count;
        o_event  = dpd_pkg::EV_NONE;
        o_data   = 8'h00;
        unique case (i_core.phase)
            dpd_pkg::PH_IDLE: begin
                priority if (i_byte == dpd_pkg::CH_START) begin
                    sum_next = 8'h00;
                    o_count  = '0;
                end else if (i_byte == dpd_pkg::CH_ACK) begin
                    o_event = dpd_pkg::EV_ACK;
                end else if (i_byte == dpd_pkg::CH_NACK) begin
                    o_event = dpd_pkg::EV_NACK;
                end else if (i_byte == dpd_pkg::CH_BREAK) begin
                    o_event = dpd_pkg::EV_BREAK;
                end else begin
                    // unknown byte outside a frame is ignored
                    o_event = dpd_pkg::EV_NONE;
                end
            end
            dpd_pkg::PH_PAYLOAD: begin
                priority if (i_byte == dpd_pkg::CH_END) begin
                    o_event = dpd_pkg::EV_NONE;
                end else if (full) begin
                    o_event = dpd_pkg::EV_DROP;
                end else begin
                    o_count  = i_count + CNT_W'(1);
                    sum_next = i_core.sum + i_byte;
                    o_event  = dpd_pkg::EV_DATA;
                    o_data   = i_byte;
                end
            end
            dpd_pkg::PH_DIGIT1: begin
                // high nibble first
                if (hex.ok) sum_next = i_core.sum ^ {hex.nib, 4'h0};
                else        o_event  = dpd_pkg::EV_BADDIGIT;
            end
            dpd_pkg::PH_DIGIT2: begin
                if (hex.ok) begin
                    sum_next = sum_lo;
                    o_event  = (sum_lo == 8'h00) ? dpd_pkg::EV_GOOD : dpd_pkg::EV_BADSUM;
                end else begin
                    o_event = dpd_pkg::EV_BADDIGIT;
                end
            end
        endcase
    end

endmodule

FILE: src/debug_packet_deframer.sv
// Debug packet deframer: each byte passes the input register, then the result
// register; one item per cycle sustained while the output is ready.
// The input register takes a byte while a result waits, so each side can
// stall without idling the other. Synchronous active-low reset clears the
// frame phase, checksum, count and both valid flags.
`include "assert_macros.svh"

module debug_packet_deframer #(
    parameter int MAX_PAYLOAD = dpd_pkg::DEFAULT_MAX_PAYLOAD
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dpd_in_if.sink    i_rx,
    dpd_out_if.source o_res
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Deframer state
    dpd_pkg::t_core   r_core;
    logic [CNT_W-1:0] r_count;

    // Result register
    logic                        r_out_valid;
    dpd_pkg::t_event             r_out_event;
    logic [7:0]                  r_out_data;
    logic [dpd_pkg::LEN_W-1:0]   r_out_len;

    dpd_pkg::t_core   n_core;
    logic [CNT_W-1:0] n_count;
    dpd_pkg::t_event  n_event;
    logic [7:0]       n_data;

    logic in_take;
    logic step;

    // Step runs when the input register holds a byte and the result slot frees
    assign step    = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || step;
    assign in_take = i_rx.valid && i_rx.ready;

    dpd_decoder #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .CNT_W       (CNT_W)
    ) u_decoder (
        .i_byte  (r_in_byte),
        .i_core  (r_core),
        .i_count (r_count),
        .o_core  (n_core),
        .o_count (n_count),
        .o_event (n_event),
        .o_data  (n_data)
    );

    // Control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_core      <= '{phase: dpd_pkg::PH_IDLE, sum: 8'h00};
            r_count     <= '0;
        end else begin
            if (in_take)   r_in_valid <= 1'b1;
            else if (step) r_in_valid <= 1'b0;

            if (step)              r_out_valid <= 1'b1;
            else if (o_res.ready)  r_out_valid <= 1'b0;

            if (step) begin
                r_core  <= n_core;
                r_count <= n_count;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) r_in_byte <= i_rx.rx_byte;
        if (step) begin
            r_out_event <= n_event;
            r_out_data  <= n_data;
            r_out_len   <= dpd_pkg::LEN_W'(n_count);
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.event_res      = r_out_event;
    assign o_res.data_byte      = r_out_data;
    assign o_res.payload_length = r_out_len;

    // Checks
    `DPD_ASSERT(a_count_limit, i_clk, i_rst_n, r_count <= CNT_W'(MAX_PAYLOAD), "count above limit")
    `DPD_ASSERT(a_in_hold, i_clk, i_rst_n, (r_in_valid && !step) |=> r_in_valid && $stable(r_in_byte), "input reg overrun")
    `DPD_ASSERT(a_digit_order, i_clk, i_rst_n, (step && r_core.phase == dpd_pkg::PH_DIGIT2) |-> $past(r_core.phase) == dpd_pkg::PH_DIGIT1 || $past(r_core.phase) == dpd_pkg::PH_DIGIT2, "second digit without first")
    `DPD_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !r_out_valid && !r_in_valid, "reset left valid set")

endmodule
